[hdl/ecg_bandpass_biquad_cascade_unit_assert.svh]
// Assertion macros for the band-pass cascade.
// Each macro expects clk and rst_n in scope.
`ifndef ECG_BANDPASS_BIQUAD_CASCADE_UNIT_ASSERT_SVH
`define ECG_BANDPASS_BIQUAD_CASCADE_UNIT_ASSERT_SVH

// Same-cycle implication.
`define ECG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ECG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/ecg_bpf_pkg.sv]
package ecg_bpf_pkg;

  localparam int SEC_N  = 4;
  localparam int SEC_W  = 2;
  localparam int ST_W   = 40;   // delay state and section values, 16 fraction bits
  localparam int FRAC_W = 16;
  localparam int ACC_W  = 44;   // section sum: input less two rounded products, or three rounded products
  localparam int CF_W   = 31;   // Q2.28 coefficient, signed
  localparam int CF_FRAC = 28;
  localparam int HALF_W = 20;   // state word is split into two 20-bit halves
  localparam int MA_W   = HALF_W + 1;
  localparam int PROD_W = MA_W + CF_W;
  localparam int FULL_W = 72;   // exact 40 x 31 product
  localparam int OUT_W  = 24;
  localparam int OUT_FRAC_DROP = FRAC_W - 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LO,
    ST_HI,
    ST_ACC,
    ST_SATW,
    ST_SATV,
    ST_FIN
  } state_t;

  // Order of the five multiply-adds of one section.
  typedef enum logic [2:0] {
    OP_A1,
    OP_A2,
    OP_B0,
    OP_B1,
    OP_B2
  } op_t;

  // Q2.28, rounded half away from zero from eight-digit decimals.
  localparam longint Q_NUM  = 268435456;
  localparam longint Q_HALF = 50000000;
  localparam longint Q_DEN  = 100000000;

  localparam longint K_A1_0 = (70682283  * Q_NUM + Q_HALF) / Q_DEN;
  localparam longint K_A2_0 = (15621030  * Q_NUM + Q_HALF) / Q_DEN;
  localparam longint K_B0_0 = (28064917  * Q_NUM + Q_HALF) / Q_DEN;
  localparam longint K_B1_0 = (56129834  * Q_NUM + Q_HALF) / Q_DEN;
  localparam longint K_A1_1 = (95028224  * Q_NUM + Q_HALF) / Q_DEN;
  localparam longint K_A2_1 = (54073140  * Q_NUM + Q_HALF) / Q_DEN;
  localparam longint K_A1_2 = (195360385 * Q_NUM + Q_HALF) / Q_DEN;
  localparam longint K_A2_2 = (95423412  * Q_NUM + Q_HALF) / Q_DEN;
  localparam longint K_A1_3 = (198048558 * Q_NUM + Q_HALF) / Q_DEN;
  localparam longint K_A2_3 = (98111344  * Q_NUM + Q_HALF) / Q_DEN;
  localparam longint K_ONE  = (100000000 * Q_NUM + Q_HALF) / Q_DEN;
  localparam longint K_TWO  = (200000000 * Q_NUM + Q_HALF) / Q_DEN;

  function automatic logic signed [CF_W-1:0] coef_f(input logic [SEC_W-1:0] sec,
                                                    input op_t op);
    longint k;
    k = 0;
    unique case (sec)
      2'd0: begin
        unique case (op)
          OP_A1:   k = K_A1_0;
          OP_A2:   k = K_A2_0;
          OP_B0:   k = K_B0_0;
          OP_B1:   k = K_B1_0;
          default: k = K_B0_0;
        endcase
      end
      2'd1: begin
        unique case (op)
          OP_A1:   k = K_A1_1;
          OP_A2:   k = K_A2_1;
          OP_B1:   k = K_TWO;
          default: k = K_ONE;
        endcase
      end
      2'd2: begin
        unique case (op)
          OP_A1:   k = -K_A1_2;
          OP_A2:   k = K_A2_2;
          OP_B1:   k = -K_TWO;
          default: k = K_ONE;
        endcase
      end
      default: begin
        unique case (op)
          OP_A1:   k = -K_A1_3;
          OP_A2:   k = K_A2_3;
          OP_B1:   k = -K_TWO;
          default: k = K_ONE;
        endcase
      end
    endcase
    return k[CF_W-1:0];
  endfunction

endpackage

[hdl/ecg_bpf_in_if.sv]
interface ecg_bpf_in_if #(
  parameter int SAMPLE_WIDTH = 10
);
  logic                    valid;
  logic                    ready;
  logic [SAMPLE_WIDTH-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

[hdl/ecg_bpf_out_if.sv]
interface ecg_bpf_out_if;
  import ecg_bpf_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] filtered;

  modport source (output valid, output filtered, input ready);
  modport sink   (input valid, input filtered, output ready);
endinterface

[hdl/ecg_bandpass_biquad_cascade_unit.sv]
// The block takes a new sample only in idle, once the last result is in the output register.
// It runs on the single 21 x 31 multiplier: each of the 20 products per
// item takes a low-half pass, a high-half pass and a round-and-accumulate step,
// plus two saturation steps per section and one output rounding step.
// Reset (rst_n low, synchronous) zeroes all delay states, idles the sequencer
// and drops any pending output beat.
module ecg_bandpass_biquad_cascade_unit #(
  parameter int SAMPLE_WIDTH = 10
) (
  input logic          clk,
  input logic          rst_n,
  ecg_bpf_in_if.sink   in_bus,
  ecg_bpf_out_if.source out_bus
);
  import ecg_bpf_pkg::*;

  // Sequencer state
  state_t           state_r, state_nxt;
  logic [SEC_W-1:0] sec_r, sec_nxt;
  op_t              op_r, op_nxt;

  // Datapath registers
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;     // running section sum
  logic signed [ST_W-1:0]   w_r, w_nxt;         // saturated w of the current section
  logic signed [PROD_W-1:0] lo_r, lo_nxt;       // low-half partial product
  logic signed [PROD_W-1:0] hi_r, hi_nxt;       // high-half partial product
  logic signed [ST_W-1:0]   d1_r [SEC_N];
  logic signed [ST_W-1:0]   d2_r [SEC_N];

  // Output register
  logic                    out_valid_r, out_valid_nxt;
  logic signed [OUT_W-1:0] out_data_r, out_data_nxt;

  logic [SAMPLE_WIDTH-1:0]  smp;
  logic                     in_fire;
  logic                     out_free;
  logic                     upd_dly;
  logic signed [ST_W-1:0]   z_sel;
  logic signed [MA_W-1:0]   mul_a;
  logic signed [CF_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [FULL_W-1:0] full_p;
  logic signed [ACC_W-1:0]  rnd_p;
  logic signed [ST_W-1:0]   acc_sat;
  logic signed [ST_W:0]     out_sum;
  logic signed [ST_W-OUT_FRAC_DROP:0] out_rnd;
  logic signed [OUT_W-1:0]  out_sat;

  assign smp      = in_bus.sample;
  assign in_fire  = in_bus.valid && in_bus.ready;
  assign out_free = !out_valid_r || out_bus.ready;

  assign in_bus.ready     = (state_r == ST_IDLE);
  assign out_bus.valid    = out_valid_r;
  assign out_bus.filtered = out_data_r;

  // Operand select: the a1/b1 terms use delay one, a2/b2 delay two, b0 uses w.
  always_comb begin
    case (op_r)
      OP_A1, OP_B1: z_sel = d1_r[sec_r];
      OP_A2, OP_B2: z_sel = d2_r[sec_r];
      default:      z_sel = w_r;
    endcase
  end

  // Shared multiplier: the low half goes in as a positive 21-bit value,
  // the high half with its sign.
  assign mul_a = (state_r == ST_HI) ? {z_sel[ST_W-1], z_sel[ST_W-1:HALF_W]}
                                    : {1'b0, z_sel[HALF_W-1:0]};
  assign mul_b = coef_f(sec_r, op_r);
  assign mul_p = mul_a * mul_b;

  // Rebuild the exact product and round to 16 fraction bits, ties upward.
  assign full_p = (FULL_W'(hi_r) <<< HALF_W) + FULL_W'(lo_r)
                  + (FULL_W'(1) <<< (CF_FRAC - 1));
  assign rnd_p  = full_p[FULL_W-1:CF_FRAC];

  // Saturate the running sum to the 40-bit state range.
  always_comb begin
    if (acc_r[ACC_W-1:ST_W-1] == {(ACC_W-ST_W+1){acc_r[ACC_W-1]}}) begin
      acc_sat = acc_r[ST_W-1:0];
    end else if (acc_r[ACC_W-1]) begin
      acc_sat = {1'b1, {(ST_W-1){1'b0}}};
    end else begin
      acc_sat = {1'b0, {(ST_W-1){1'b1}}};
    end
  end

  // Final rounding: drop 8 fraction bits with +1/2, then saturate to 24 bits.
  assign out_sum = {acc_r[ST_W-1], acc_r[ST_W-1:0]}
                   + (ST_W+1)'(1 <<< (OUT_FRAC_DROP - 1));
  assign out_rnd = out_sum[ST_W:OUT_FRAC_DROP];

  always_comb begin
    if (out_rnd[ST_W-OUT_FRAC_DROP:OUT_W-1] ==
        {(ST_W-OUT_FRAC_DROP-OUT_W+2){out_rnd[ST_W-OUT_FRAC_DROP]}}) begin
      out_sat = out_rnd[OUT_W-1:0];
    end else if (out_rnd[ST_W-OUT_FRAC_DROP]) begin
      out_sat = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      out_sat = {1'b0, {(OUT_W-1){1'b1}}};
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_LO;
        end
      end
      ST_LO:   state_nxt = ST_HI;
      ST_HI:   state_nxt = ST_ACC;
      ST_ACC: begin
        if (op_r == OP_A2) begin
          state_nxt = ST_SATW;
        end else if (op_r == OP_B2) begin
          state_nxt = ST_SATV;
        end else begin
          state_nxt = ST_LO;
        end
      end
      ST_SATW: state_nxt = ST_LO;
      ST_SATV: begin
        if (sec_r == SEC_W'(SEC_N - 1)) begin
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_LO;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and output control
  always_comb begin
    sec_nxt       = sec_r;
    op_nxt        = op_r;
    acc_nxt       = acc_r;
    w_nxt         = w_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    upd_dly       = 1'b0;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_bus.ready;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          // load the sample as an integer with 16 fraction bits
          acc_nxt = {{(ACC_W-SAMPLE_WIDTH-FRAC_W){1'b0}}, smp, {FRAC_W{1'b0}}};
          sec_nxt = '0;
          op_nxt  = OP_A1;
        end
      end
      ST_LO: lo_nxt = mul_p;
      ST_HI: hi_nxt = mul_p;
      ST_ACC: begin
        if (op_r == OP_A1 || op_r == OP_A2) begin
          acc_nxt = acc_r - rnd_p;
        end else begin
          acc_nxt = acc_r + rnd_p;
        end
        if (op_r != OP_A2 && op_r != OP_B2) begin
          op_nxt = op_t'(op_r + 3'd1);
        end
      end
      ST_SATW: begin
        w_nxt   = acc_sat;
        acc_nxt = '0;
        op_nxt  = OP_B0;
      end
      ST_SATV: begin
        // saturated section output feeds the next section
        acc_nxt = ACC_W'(acc_sat);
        upd_dly = 1'b1;
        op_nxt  = OP_A1;
        if (sec_r != SEC_W'(SEC_N - 1)) begin
          sec_nxt = sec_r + SEC_W'(1);
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_data_nxt  = out_sat;
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sec_r       <= '0;
      op_r        <= OP_A1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sec_r       <= sec_nxt;
      op_r        <= op_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Delay line: shift the section's two states when its output is done.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SEC_N; i++) begin
        d1_r[i] <= '0;
        d2_r[i] <= '0;
      end
    end else if (upd_dly) begin
      d2_r[sec_r] <= d1_r[sec_r];
      d1_r[sec_r] <= w_r;
    end
  end

  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    w_r        <= w_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    out_data_r <= out_data_nxt;
  end

`include "ecg_bandpass_biquad_cascade_unit_assert.svh"

  `ECG_ASSERT_NEXT(a_sec_hold, (state_r != ST_SATV && state_r != ST_IDLE), $stable(sec_r), "section index moved outside a section boundary")
  `ECG_ASSERT_NEXT(a_acc_clear, (state_r == ST_SATW), (acc_r == '0), "sum not cleared after w saturation")
  `ECG_ASSERT_NEXT(a_fin_out, (state_r == ST_FIN && out_free), (out_valid_r && state_r == ST_IDLE), "finished item did not reach the output register")
  `ECG_ASSERT_NOW(a_busy_out, (state_r != ST_IDLE && state_r != ST_FIN), !in_bus.ready, "input taken while a sample is in flight")

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps

module tb;
  import ecg_bpf_pkg::*;

  localparam int SAMPLE_W = 10;
  localparam longint SAMPLE_MAX = (64'sd1 <<< SAMPLE_W) - 1;

  // 40-bit state limits and 24-bit output limits
  localparam longint STATE_HI = (64'sd1 <<< (ST_W - 1)) - 1;
  localparam longint STATE_LO = -(64'sd1 <<< (ST_W - 1));
  localparam longint OUT_HI   = (64'sd1 <<< (OUT_W - 1)) - 1;
  localparam longint OUT_LO   = -(64'sd1 <<< (OUT_W - 1));

  // Q2.28 conversion from eight-digit decimals
  localparam longint Q28_ONE  = 268435456;
  localparam longint DEC_HALF = 50000000;
  localparam longint DEC_ONE  = 100000000;

  localparam int RANDOM_ITEMS  = 1000;
  localparam int MAX_WAIT      = 17;
  localparam int HOLD_AT       = 150;   // result count at which the sink holds off
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_CYCLES  = 90;    // settle time after the last output, longer than one item's latency
  localparam int STALL_LIMIT   = 3000;  // cycles without any beat before giving up
  localparam int DIR_N         = 24;

  typedef enum int {
    PAT_NOISE,
    PAT_SQUARE,
    PAT_HOLD,
    PAT_RAMP,
    PAT_EXTREME
  } pattern_t;

  typedef struct {
    logic [SAMPLE_W-1:0]     sample;
    bit                      typed;
    logic signed [OUT_W-1:0] filtered;
  } stim_row_t;

  logic clk;
  logic rst_n;

  ecg_bpf_in_if #(.SAMPLE_WIDTH(SAMPLE_W)) in_bus ();
  ecg_bpf_out_if                           out_bus ();

  ecg_bandpass_biquad_cascade_unit #(
    .SAMPLE_WIDTH(SAMPLE_W)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  // Filter model state: coefficients per section and op, two delay taps
  // per section, and the outputs still owed by the block, oldest first.
  longint                  coef_q28 [SEC_N][5];
  logic signed [ST_W-1:0]  tap_one [SEC_N];
  logic signed [ST_W-1:0]  tap_two [SEC_N];
  logic signed [OUT_W-1:0] filtered_q [$];
  int                      mismatches;

  // Convert an eight-digit decimal coefficient to Q2.28, ties away from zero.
  function automatic longint to_q28(input longint dec);
    if (dec < 0) begin
      return -((-dec * Q28_ONE + DEC_HALF) / DEC_ONE);
    end
    return (dec * Q28_ONE + DEC_HALF) / DEC_ONE;
  endfunction

  // Multiply a state value by a Q2.28 coefficient and round to 16 fraction
  // bits; ties go toward +infinity. The 96-bit product is exact.
  function automatic longint q28_product(input logic signed [ST_W-1:0] z,
                                         input longint c);
    logic signed [95:0] prod;
    prod = 96'(z) * 96'(c) + 96'sd134217728;
    return 64'(prod >>> CF_FRAC);
  endfunction

  function automatic longint clamp(input longint v, input longint lo,
                                   input longint hi);
    if (v < lo) begin
      return lo;
    end
    if (v > hi) begin
      return hi;
    end
    return v;
  endfunction

  // Run one sample through the four sections and advance the delay taps.
  function automatic logic signed [OUT_W-1:0] bandpass_step(
      input logic [SAMPLE_W-1:0] smp);
    longint                 v;
    longint                 w;
    logic signed [ST_W-1:0] z1;
    logic signed [ST_W-1:0] z2;
    logic signed [ST_W-1:0] w_st;
    v = longint'(smp) <<< FRAC_W;
    for (int s = 0; s < SEC_N; s++) begin
      z1 = tap_one[s];
      z2 = tap_two[s];
      w = v - q28_product(z1, coef_q28[s][OP_A1]) - q28_product(z2, coef_q28[s][OP_A2]);
      w = clamp(w, STATE_LO, STATE_HI);
      w_st = w[ST_W-1:0];
      v = q28_product(w_st, coef_q28[s][OP_B0]) + q28_product(z1, coef_q28[s][OP_B1])
        + q28_product(z2, coef_q28[s][OP_B2]);
      v = clamp(v, STATE_LO, STATE_HI);
      tap_two[s] = z1;
      tap_one[s] = w_st;
    end
    v = clamp((v + 128) >>> OUT_FRAC_DROP, OUT_LO, OUT_HI);
    return v[OUT_W-1:0];
  endfunction

  // Print one line per mismatch and count it.
  task automatic note_mismatch(input string what, input longint exp_v,
                               input longint got_v);
    $display("%0t: mismatch, %s: expected %0d, got %0d", $realtime, what, exp_v, got_v);
    mismatches++;
  endtask

  // Free-running clock, 10 ns period.
  initial begin
    clk = 1'b0;
    forever begin
      #5 clk = ~clk;
    end
  end

  // Watchdog: count cycles in which neither channel moves a beat, and give
  // up once the count reaches the limit. Reset cycles do not count.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("RESULT: ERROR");
          $finish;
        end
      end
    end
  end

  // Result side: draw a stall for every beat, with stall-free stretches,
  // and one long hold-off so the block backs up and stalls its input.
  initial begin : result_side
    int                      stall;
    int                      n_seen;
    logic signed [OUT_W-1:0] want;
    out_bus.ready <= 1'b0;
    n_seen = 0;
    @(posedge clk);
    while (!rst_n) begin
      @(posedge clk);
    end
    forever begin
      stall = ((n_seen / 80) % 3 == 1) ? 0 : $urandom_range(0, MAX_WAIT);
      if (n_seen == HOLD_AT) begin
        stall = HOLD_CYCLES;
      end
      // Drop ready only when a stall is due; otherwise hold it high.
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      do begin
        @(posedge clk);
      end while (!out_bus.valid);
      // A result beat moved at this edge: match it against the oldest owed output.
      if (filtered_q.size() == 0) begin
        note_mismatch("filtered beat with nothing pending", 0, longint'(out_bus.filtered));
      end else begin
        want = filtered_q.pop_front();
        if (out_bus.filtered !== want) begin
          note_mismatch("filtered", longint'(want), longint'(out_bus.filtered));
        end
      end
      n_seen++;
    end
  end

  // Offer one sample beat after a random gap; once it is taken, run the
  // model and queue the output owed for it. A typed row overrides the
  // model's value but the model still advances.
  task automatic offer_sample(input logic [SAMPLE_W-1:0] smp, input bit typed,
                              input logic signed [OUT_W-1:0] typed_val,
                              input int item_no);
    int                      gap;
    logic signed [OUT_W-1:0] pred;
    gap = ((item_no / 96) % 3 == 2) ? 0 : $urandom_range(0, MAX_WAIT);
    // Keep valid high across back-to-back beats; drop it only for a gap.
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid  <= 1'b1;
    in_bus.sample <= smp;
    do begin
      @(posedge clk);
    end while (!in_bus.ready);
    pred = bandpass_step(smp);
    filtered_q.push_back(typed ? typed_val : pred);
  endtask

  initial begin : stimulus
    stim_row_t                dir_rows [DIR_N];
    pattern_t                 pat;
    int                       seg_len;
    int                       item_no;
    int                       half_period;
    int                       phase;
    longint                   level_hi;
    longint                   level_lo;
    longint                   cur;
    longint                   step;
    logic [SAMPLE_W-1:0]      smp;

    // Drive every block input to a known value from time zero.
    rst_n         <= 1'b0;
    in_bus.valid  <= 1'b0;
    in_bus.sample <= '0;
    mismatches    = 0;

    // Section coefficients: a1, a2, b0, b1, b2.
    coef_q28[0][OP_A1] = to_q28(70682283);
    coef_q28[0][OP_A2] = to_q28(15621030);
    coef_q28[0][OP_B0] = to_q28(28064917);
    coef_q28[0][OP_B1] = to_q28(56129834);
    coef_q28[0][OP_B2] = to_q28(28064917);
    coef_q28[1][OP_A1] = to_q28(95028224);
    coef_q28[1][OP_A2] = to_q28(54073140);
    coef_q28[1][OP_B0] = to_q28(100000000);
    coef_q28[1][OP_B1] = to_q28(200000000);
    coef_q28[1][OP_B2] = to_q28(100000000);
    coef_q28[2][OP_A1] = to_q28(-195360385);
    coef_q28[2][OP_A2] = to_q28(95423412);
    coef_q28[2][OP_B0] = to_q28(100000000);
    coef_q28[2][OP_B1] = to_q28(-200000000);
    coef_q28[2][OP_B2] = to_q28(100000000);
    coef_q28[3][OP_A1] = to_q28(-198048558);
    coef_q28[3][OP_A2] = to_q28(98111344);
    coef_q28[3][OP_B0] = to_q28(100000000);
    coef_q28[3][OP_B1] = to_q28(-200000000);
    coef_q28[3][OP_B2] = to_q28(100000000);

    // Delay taps start at zero, as the block's reset leaves them.
    for (int s = 0; s < SEC_N; s++) begin
      tap_one[s] = '0;
      tap_two[s] = '0;
    end

    // Directed rows. Zero in from a cleared filter must give zero out; the
    // rest check the model. Full-swing steps and a held top value drive the
    // resonant low-frequency sections toward their state limits; the mixed
    // bit patterns toggle every sample bit.
    dir_rows = '{
      '{10'd0,    1'b1, 24'sd0},
      '{10'd0,    1'b1, 24'sd0},
      '{10'd1023, 1'b0, 24'sd0},
      '{10'd1023, 1'b0, 24'sd0},
      '{10'd1023, 1'b0, 24'sd0},
      '{10'd1023, 1'b0, 24'sd0},
      '{10'd0,    1'b0, 24'sd0},
      '{10'd0,    1'b0, 24'sd0},
      '{10'd1023, 1'b0, 24'sd0},
      '{10'd0,    1'b0, 24'sd0},
      '{10'd1023, 1'b0, 24'sd0},
      '{10'd0,    1'b0, 24'sd0},
      '{10'd1,    1'b0, 24'sd0},
      '{10'd1022, 1'b0, 24'sd0},
      '{10'd512,  1'b0, 24'sd0},
      '{10'd511,  1'b0, 24'sd0},
      '{10'd682,  1'b0, 24'sd0},
      '{10'd341,  1'b0, 24'sd0},
      '{10'd1023, 1'b0, 24'sd0},
      '{10'd1023, 1'b0, 24'sd0},
      '{10'd1023, 1'b0, 24'sd0},
      '{10'd1023, 1'b0, 24'sd0},
      '{10'd0,    1'b0, 24'sd0},
      '{10'd0,    1'b0, 24'sd0}
    };

    // Hold reset, then release it for good.
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    item_no = 0;
    foreach (dir_rows[i]) begin
      offer_sample(dir_rows[i].sample, dir_rows[i].typed, dir_rows[i].filtered, item_no);
      item_no++;
    end

    // Random part in segments. Most segments are shaped signals (square
    // waves near the pass band, ramps, held levels, full-scale flips) that
    // excite the filter hard; the rest is plain noise.
    while (item_no < DIR_N + RANDOM_ITEMS) begin
      pat         = pattern_t'($urandom_range(PAT_NOISE, PAT_EXTREME));
      seg_len     = $urandom_range(20, 90);
      half_period = $urandom_range(1, 40);
      phase       = 0;
      if ($urandom_range(0, 3) != 0) begin
        level_hi = SAMPLE_MAX;
        level_lo = 0;
      end else begin
        level_hi = longint'($urandom_range(0, 32'(SAMPLE_MAX)));
        level_lo = longint'($urandom_range(0, 32'(SAMPLE_MAX)));
      end
      cur  = longint'($urandom_range(0, 32'(SAMPLE_MAX)));
      step = longint'($urandom_range(1, 64));
      for (int k = 0; k < seg_len; k++) begin
        case (pat)
          PAT_NOISE: begin
            smp = SAMPLE_W'($urandom_range(0, 32'(SAMPLE_MAX)));
          end
          PAT_SQUARE: begin
            smp = ((phase / half_period) % 2 == 0) ? level_hi[SAMPLE_W-1:0]
                                                   : level_lo[SAMPLE_W-1:0];
            phase++;
          end
          PAT_HOLD: begin
            smp = level_hi[SAMPLE_W-1:0];
          end
          PAT_RAMP: begin
            // Advance and wrap at the sample width.
            cur = (cur + step) & SAMPLE_MAX;
            smp = cur[SAMPLE_W-1:0];
          end
          default: begin
            smp = $urandom_range(0, 1) ? SAMPLE_MAX[SAMPLE_W-1:0] : '0;
          end
        endcase
        offer_sample(smp, 1'b0, 24'sd0, item_no);
        item_no++;
      end
    end
    in_bus.valid <= 1'b0;

    // Wait for every owed output, then let the pipeline settle so any
    // stray extra beat shows up.
    while (filtered_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
